### design/ccre_pkg.sv
// Shared types and constants for the character canvas raster engine.
// Holds the transaction structs, command codes and back-end state encoding.
// No dependencies.
`default_nettype none

package ccre_pkg;

   localparam logic [2:0] CMD_CLEAR      = 3'd0;
   localparam logic [2:0] CMD_POINT      = 3'd1;
   localparam logic [2:0] CMD_RECT       = 3'd2;
   localparam logic [2:0] CMD_FILLRECT   = 3'd3;
   localparam logic [2:0] CMD_CIRCLE     = 3'd4;
   localparam logic [2:0] CMD_FILLCIRCLE = 3'd5;
   localparam logic [2:0] CMD_LINE       = 3'd6;
   localparam logic [2:0] CMD_READ       = 3'd7;

   localparam logic [7:0] SPACE_CHAR = 8'd32;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] row_a;
      logic [5:0] col_a;
      logic [5:0] row_b;
      logic [5:0] col_b;
      logic [6:0] radius;
      logic [7:0] pen_char;
   } cmd_type;

   typedef struct packed {
      logic [2:0] done_kind;
      logic [7:0] read_char;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_SCAN,
      OP_LINE,
      OP_READ
   } op_type;

   // Decoded job: line/point walk is pre-oriented so the major axis rises.
   typedef struct packed {
      cmd_type    cmd;
      op_type     op;
      logic       row_major;
      logic       step_neg;
      logic [5:0] maj0;
      logic [5:0] min0;
      logic [5:0] maj1;
      logic [5:0] dmaj;
      logic [5:0] dmin;
   } job_type;

   typedef struct packed {
      logic init;
      logic take;
   } back_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_LINE,
      ST_READ,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

### design/ccre_front.sv
// Front end: accepts command transactions, decodes them into jobs and
// queues them in a two-entry FIFO for the back end. Depends on ccre_pkg.
`default_nettype none

module ccre_front import ccre_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire cmd_type       req_data,
   output logic               job_valid,
   output job_type            job,
   input  wire back_stat_type stat
);

   job_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   job_type    new_job;
   logic [5:0] dr, dc, a0, b0, a1, b1;
   logic       rmaj;

   always_comb begin
      dr   = (req_data.row_b > req_data.row_a) ? req_data.row_b - req_data.row_a
                                               : req_data.row_a - req_data.row_b;
      dc   = (req_data.col_b > req_data.col_a) ? req_data.col_b - req_data.col_a
                                               : req_data.col_a - req_data.col_b;
      rmaj = (dr >= dc);
      a0   = rmaj ? req_data.row_a : req_data.col_a;
      b0   = rmaj ? req_data.col_a : req_data.row_a;
      a1   = rmaj ? req_data.row_b : req_data.col_b;
      b1   = rmaj ? req_data.col_b : req_data.row_b;
      if (a0 > a1) begin
         a0 = a1;
         a1 = rmaj ? req_data.row_a : req_data.col_a;
         b0 = b1;
         b1 = rmaj ? req_data.col_a : req_data.row_a;
      end
      new_job.cmd       = req_data;
      new_job.row_major = rmaj;
      new_job.step_neg  = (b1 < b0);
      new_job.maj0      = a0;
      new_job.min0      = b0;
      new_job.maj1      = a1;
      new_job.dmaj      = a1 - a0;
      new_job.dmin      = (b1 < b0) ? b0 - b1 : b1 - b0;
      case (req_data.kind)
         CMD_LINE: new_job.op = OP_LINE;
         CMD_READ: new_job.op = OP_READ;
         CMD_POINT: begin
            // single cell walk
            new_job.op        = OP_LINE;
            new_job.row_major = 1'b1;
            new_job.step_neg  = 1'b0;
            new_job.maj0      = req_data.row_a;
            new_job.min0      = req_data.col_a;
            new_job.maj1      = req_data.row_a;
            new_job.dmaj      = 6'd0;
            new_job.dmin      = 6'd0;
         end
         default: new_job.op = OP_SCAN;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2) || stat.init;
   assign push      = req_valid && !req_stall;
   assign pop       = stat.take;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= new_job;
      end
   end

endmodule

`default_nettype wire

### design/ccre_back.sv
// Back end: executes jobs against the canvas memory (scan pipeline for
// clear/rect/circle, stepping walker for line/point, read port) and holds
// the result register. Depends on ccre_pkg.
`default_nettype none

module ccre_back import ccre_pkg::*; #(
   parameter int ROWS = 64,
   parameter int COLS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output back_stat_type stat,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

   back_state_type state_ff, state_in;
   logic           init_ff, init_in;
   logic           take, load;
   job_type        job_ff;
   logic [2:0]     kind_eff;

   logic [7:0]     mem_ff [CELLS];
   logic [7:0]     rd_q_ff;
   logic           we;
   logic [AW-1:0]  wa;
   logic [7:0]     wd;

   // scan pipeline
   logic [RW-1:0]  r_ff, p1_r_ff, p2_r_ff, p3_r_ff;
   logic [CW-1:0]  c_ff, p1_c_ff, p2_c_ff, p3_c_ff;
   logic [AW-1:0]  a_ff, p1_a_ff, p2_a_ff, p3_a_ff;
   logic           p1_v_ff, p2_v_ff, p3_v_ff;
   logic [7:0]     p1_dr_ff, p1_dc_ff, r8, c8, cr8, cc8;
   logic [15:0]    p2_sr_ff, p2_sc_ff;
   logic [16:0]    p3_s_ff;
   logic [10:0]    hv_ff, lv_ff;
   logic [20:0]    hi_ff, lo_ff;
   logic [13:0]    rr_ff;
   logic           scan_last;

   logic [23:0]    s100;
   logic [8:0]     pr, pc, top, bot, lft, rgt;
   logic           in_rows, in_cols, on_ring, hit;

   // line walker
   logic [5:0]        ma_ff, mi_ff, lr, lc;
   logic signed [9:0] d_ff, d_in;
   logic              line_ok;
   logic [15:0]       line_addr, rd_addr;
   logic              rd_ok;

   assign kind_eff  = init_ff ? CMD_CLEAR : job_ff.cmd.kind;
   assign scan_last = (r_ff == RW'(ROWS - 1)) && (c_ff == CW'(COLS - 1));
   assign stat.init = init_ff;
   assign stat.take = take;

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      take     = 1'b0;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               take = 1'b1;
               case (job.op)
                  OP_LINE: state_in = ST_LINE;
                  OP_READ: state_in = ST_READ;
                  default: begin
                     if (job.cmd.kind == CMD_CIRCLE || job.cmd.kind == CMD_FILLCIRCLE) begin
                        state_in = ST_PREP;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_PREP: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff && !p3_v_ff) begin
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_LINE: begin
            if (ma_ff == job_ff.maj1) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SCAN;
         init_ff   <= 1'b1;
         rsp_valid <= 1'b0;
         r_ff      <= '0;
         c_ff      <= '0;
         a_ff      <= '0;
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
         p3_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         if (load) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         if (take) begin
            r_ff <= '0;
            c_ff <= '0;
            a_ff <= '0;
         end else if (state_ff == ST_SCAN) begin
            a_ff <= a_ff + AW'(1);
            if (c_ff == CW'(COLS - 1)) begin
               c_ff <= '0;
               r_ff <= r_ff + RW'(1);
            end else begin
               c_ff <= c_ff + CW'(1);
            end
         end
         p1_v_ff <= (state_ff == ST_SCAN);
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   // scan datapath
   always_comb begin
      r8  = 8'(r_ff);
      c8  = 8'(c_ff);
      cr8 = 8'(job_ff.cmd.row_a);
      cc8 = 8'(job_ff.cmd.col_a);
   end

   always_ff @(posedge clock) begin
      p1_r_ff  <= r_ff;
      p1_c_ff  <= c_ff;
      p1_a_ff  <= a_ff;
      p1_dr_ff <= (r8 > cr8) ? r8 - cr8 : cr8 - r8;
      p1_dc_ff <= (c8 > cc8) ? c8 - cc8 : cc8 - c8;
      p2_r_ff  <= p1_r_ff;
      p2_c_ff  <= p1_c_ff;
      p2_a_ff  <= p1_a_ff;
      p2_sr_ff <= 16'(p1_dr_ff) * 16'(p1_dr_ff);
      p2_sc_ff <= 16'(p1_dc_ff) * 16'(p1_dc_ff);
      p3_r_ff  <= p2_r_ff;
      p3_c_ff  <= p2_c_ff;
      p3_a_ff  <= p2_a_ff;
      p3_s_ff  <= 17'(p2_sr_ff) + 17'(p2_sc_ff);
      if (take) begin
         job_ff <= job;
         hv_ff  <= 11'(job.cmd.radius) * 11'd10 + 11'd7;
         lv_ff  <= 11'(job.cmd.radius) * 11'd10 - 11'd7;
         ma_ff  <= job.maj0;
         mi_ff  <= job.min0;
         d_ff   <= $signed({3'b000, job.dmin, 1'b0}) - $signed({4'b0000, job.dmaj});
      end else if (state_ff == ST_LINE) begin
         ma_ff <= ma_ff + 6'd1;
         d_ff  <= d_in;
         if (d_ff > 10'sd0) begin
            mi_ff <= job_ff.step_neg ? mi_ff - 6'd1 : mi_ff + 6'd1;
         end
      end
      if (state_ff == ST_PREP) begin
         hi_ff <= 21'(hv_ff) * 21'(hv_ff);
         lo_ff <= 21'(lv_ff) * 21'(lv_ff);
         rr_ff <= 14'(job_ff.cmd.radius) * 14'(job_ff.cmd.radius);
      end
   end

   always_comb begin
      s100    = {1'b0, p3_s_ff, 6'b0} + {2'b0, p3_s_ff, 5'b0} + {5'b0, p3_s_ff, 2'b0};
      on_ring = (s100 < 24'(hi_ff)) &&
                ((job_ff.cmd.radius == 7'd0) || (s100 > 24'(lo_ff)));
      pr      = 9'(p3_r_ff);
      pc      = 9'(p3_c_ff);
      top     = 9'(job_ff.cmd.row_a);
      lft     = 9'(job_ff.cmd.col_a);
      bot     = 9'(job_ff.cmd.row_b);
      rgt     = 9'(job_ff.cmd.col_b);
      in_rows = (top <= pr) && (pr <= bot);
      in_cols = (lft <= pc) && (pc <= rgt);
      case (kind_eff)
         CMD_CLEAR:      hit = 1'b1;
         CMD_RECT:       hit = ((pr == top || pr == bot) && in_cols) ||
                               ((pc == lft || pc == rgt) && in_rows);
         CMD_FILLRECT:   hit = in_rows && in_cols;
         CMD_CIRCLE:     hit = on_ring;
         CMD_FILLCIRCLE: hit = on_ring || (p3_s_ff <= 17'(rr_ff));
         default:        hit = 1'b0;
      endcase
   end

   // line walker
   always_comb begin
      d_in = d_ff + $signed({3'b000, job_ff.dmin, 1'b0});
      if (d_ff > 10'sd0) begin
         d_in = d_in - $signed({3'b000, job_ff.dmaj, 1'b0});
      end
      lr        = job_ff.row_major ? ma_ff : mi_ff;
      lc        = job_ff.row_major ? mi_ff : ma_ff;
      line_ok   = (9'(lr) < 9'(ROWS)) && (9'(lc) < 9'(COLS));
      line_addr = 16'(lr) * 16'(COLS) + 16'(lc);
      rd_ok     = (9'(job_ff.cmd.row_a) < 9'(ROWS)) && (9'(job_ff.cmd.col_a) < 9'(COLS));
      rd_addr   = 16'(job_ff.cmd.row_a) * 16'(COLS) + 16'(job_ff.cmd.col_a);
   end

   always_comb begin
      we = 1'b0;
      wa = p3_a_ff;
      wd = job_ff.cmd.pen_char;
      if (p3_v_ff && hit) begin
         we = 1'b1;
         wd = (kind_eff == CMD_CLEAR) ? SPACE_CHAR : job_ff.cmd.pen_char;
      end else if (state_ff == ST_LINE && line_ok) begin
         we = 1'b1;
         wa = line_addr[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rd_q_ff <= mem_ff[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data.done_kind <= job_ff.cmd.kind;
         rsp_data.read_char <= (job_ff.cmd.kind == CMD_READ && rd_ok) ? rd_q_ff : 8'd0;
      end
   end

endmodule

`default_nettype wire

### design/character_canvas_raster_engine.sv
// Top level of the character canvas raster engine: front-end decoder and
// queue feeding the back-end canvas executor. Depends on ccre_pkg,
// ccre_front and ccre_back.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   req_data  (cmd_type)
//   rsp      out  rsp_valid / rsp_stall   rsp_data  (rsp_type)
//
// Clear, rectangle and circle commands sweep every cell, one cell per cycle
// through the canvas write port; circles first pass a prep state.
// Lines and points walk the major axis, writing one cell per cycle.
// After reset a clearing pass over every cell runs with req_stall high.
// Up to two commands queue while the back end works or rsp is stalled.
`default_nettype none

module character_canvas_raster_engine import ccre_pkg::*; #(
   parameter int ROWS = 64,
   parameter int COLS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire cmd_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic          job_valid;
   job_type       job;
   back_stat_type stat;

   ccre_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .stat      (stat)
   );

   ccre_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      stat.init |-> req_stall) else $error("transaction accepted during clearing pass");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      stat.take |-> job_valid) else $error("back end took from empty queue");
   a_take_once: assert property (@(posedge clock) disable iff (reset)
      stat.take |=> !stat.take) else $error("back end took two jobs in a row");
`endif

endmodule

`default_nettype wire
